### hdl/dhot_pkg.sv
// shared types and codes for the double-hashing open-addressed table
package dhot_pkg;

  // fixed widths of the request and result fields
  localparam int HashW  = 32;
  localparam int ValueW = 32;
  localparam int KeyInW = 32;
  localparam int PosW   = 11;
  localparam int CntW   = 11;
  localparam int BitCntW = $clog2(HashW);

  // operation codes
  localparam logic [1:0] OpInsert   = 2'd0;
  localparam logic [1:0] OpRemove   = 2'd1;
  localparam logic [1:0] OpLookup   = 2'd2;
  localparam logic [1:0] OpReserved = 2'd3;

  // result status codes
  localparam logic [1:0] StatOk   = 2'd0;
  localparam logic [1:0] StatDup  = 2'd1;
  localparam logic [1:0] StatMiss = 2'd2;
  localparam logic [1:0] StatFull = 2'd3;

  // slot status codes held in the status memory
  localparam logic [1:0] SlotEmpty   = 2'd0;
  localparam logic [1:0] SlotUsed    = 2'd1;
  localparam logic [1:0] SlotVacated = 2'd2;

  // sequencer states
  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StModFirst,
    StModStep,
    StProbe,
    StCheck,
    StDone
  } dhot_state_e;

endpackage

### hdl/dhot_ram.sv
// generic single-write, single-read ram with registered read data
module dhot_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/double_hash_open_table.sv
// open-addressed hash table with double hashing over three slot memories
// a full-table insert or reserved op goes straight to the result; any other request first
//   reduces the first and then the step hash mod p bit by bit, then reads and checks one
//   slot per probe and loads the result, all through one shared add/compare/subtract unit
// throughput: one word at a time, the next accepted in the cycle after the result is loaded
// reset: status memory is cleared by a sweep over all TABLE_DEPTH slots, in_ready_o low
module double_hash_open_table
  import dhot_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024,
  parameter int KEY_WIDTH   = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration
  input  logic              cfg_we_i,
  input  logic [PosW-1:0]   cfg_wdata_i,
  // request channel
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        operation_i,
  input  logic [KeyInW-1:0] key_i,
  input  logic [ValueW-1:0] value_i,
  input  logic [HashW-1:0]  first_hash_i,
  input  logic [HashW-1:0]  step_hash_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        status_o,
  output logic [ValueW-1:0] found_value_o,
  output logic [CntW-1:0]   entry_count_o
);

  localparam int AddrW   = $clog2(TABLE_DEPTH);
  localparam int KeyBits = (KEY_WIDTH < KeyInW) ? KEY_WIDTH : KeyInW;
  localparam logic [PosW-1:0] PosReset =
      PosW'((TABLE_DEPTH < 1024) ? TABLE_DEPTH : 1024);
  localparam logic [AddrW-1:0] ClrLast = AddrW'(TABLE_DEPTH - 1);

  dhot_state_e state_q, state_d;

  logic [PosW-1:0]    p_q, p_d;
  logic [CntW-1:0]    count_q, count_d;
  logic [AddrW-1:0]   clr_q, clr_d;
  logic [1:0]         op_q, op_d;
  logic [KeyBits-1:0] key_q, key_d;
  logic [ValueW-1:0]  val_q, val_d;
  logic [HashW-1:0]   h2_q, h2_d;
  logic [HashW-1:0]   sh_q, sh_d;
  logic [BitCntW-1:0] bit_q, bit_d;
  logic [PosW-1:0]    pos_q, pos_d;
  logic [PosW-1:0]    stride_q, stride_d;
  logic [PosW-1:0]    cur_q, cur_d;
  logic [PosW-1:0]    free_q, free_d;
  logic               have_free_q, have_free_d;
  logic [PosW-1:0]    i_q, i_d;
  logic [1:0]         res_stat_q, res_stat_d;
  logic [ValueW-1:0]  res_val_q, res_val_d;
  logic               out_valid_q, out_valid_d;
  logic [1:0]         out_stat_q, out_stat_d;
  logic [ValueW-1:0]  out_val_q, out_val_d;
  logic [CntW-1:0]    out_cnt_q, out_cnt_d;

  // memory ports
  logic               st_we, kv_we;
  logic [AddrW-1:0]   st_waddr, kv_waddr, raddr;
  logic [1:0]         st_wdata, st_rdata;
  logic [KeyBits-1:0] key_rdata;
  logic [ValueW-1:0]  val_rdata;

  // shared add, compare and subtract-modulus unit
  logic [PosW:0] unit_a, unit_b, unit_sum, unit_out;

  // probe check decisions
  logic            chk_match, chk_empty, chk_last, chk_free, chk_finish;
  logic [PosW-1:0] wr_slot;

  assign raddr = AddrW'(pos_q);

  dhot_ram #(.WIDTH(2), .DEPTH(TABLE_DEPTH)) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (raddr),
    .rdata_o (st_rdata)
  );

  dhot_ram #(.WIDTH(KeyBits), .DEPTH(TABLE_DEPTH)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (kv_we),
    .waddr_i (kv_waddr),
    .wdata_i (key_q),
    .raddr_i (raddr),
    .rdata_o (key_rdata)
  );

  dhot_ram #(.WIDTH(ValueW), .DEPTH(TABLE_DEPTH)) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (kv_we),
    .waddr_i (kv_waddr),
    .wdata_i (val_q),
    .raddr_i (raddr),
    .rdata_o (val_rdata)
  );

  // operand select for the shared unit
  always_comb begin
    unique case (state_q)
      StModFirst: begin
        unit_a = {pos_q, 1'b0};
        unit_b = {{PosW{1'b0}}, sh_q[HashW-1]};
      end
      StModStep: begin
        unit_a = {stride_q, 1'b0};
        unit_b = {{PosW{1'b0}}, sh_q[HashW-1]};
      end
      default: begin
        unit_a = {1'b0, pos_q};
        unit_b = {1'b0, stride_q};
      end
    endcase
  end

  // sum, then one conditional subtract of the modulus
  assign unit_sum = unit_a + unit_b;
  assign unit_out = (unit_sum >= {1'b0, p_q}) ? (unit_sum - {1'b0, p_q}) : unit_sum;

  // decisions on the slot just read
  always_comb begin
    chk_match = (st_rdata == SlotUsed) && (key_rdata == key_q);
    chk_empty = (st_rdata == SlotEmpty);
    chk_free  = (st_rdata != SlotUsed);
    chk_last  = (i_q == (p_q - PosW'(1)));
    wr_slot   = have_free_q ? free_q : cur_q;
    chk_finish = chk_match || chk_empty || chk_last;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StClear: begin
        if (clr_q == ClrLast) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_valid_i) begin
          if ((operation_i == OpReserved) ||
              ((operation_i == OpInsert) && (count_q >= p_q))) begin
            state_d = StDone;
          end else begin
            state_d = StModFirst;
          end
        end
      end
      StModFirst: begin
        if (bit_q == BitCntW'(HashW - 1)) begin
          state_d = StModStep;
        end
      end
      StModStep: begin
        if (bit_q == BitCntW'(HashW - 1)) begin
          state_d = StProbe;
        end
      end
      StProbe: state_d = StCheck;
      StCheck: begin
        state_d = chk_finish ? StDone : StProbe;
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StClear;
    endcase
  end

  // datapath, memory writes and handshake outputs
  always_comb begin
    p_d         = p_q;
    count_d     = count_q;
    clr_d       = clr_q;
    op_d        = op_q;
    key_d       = key_q;
    val_d       = val_q;
    h2_d        = h2_q;
    sh_d        = sh_q;
    bit_d       = bit_q;
    pos_d       = pos_q;
    stride_d    = stride_q;
    cur_d       = cur_q;
    free_d      = free_q;
    have_free_d = have_free_q;
    i_d         = i_q;
    res_stat_d  = res_stat_q;
    res_val_d   = res_val_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_stat_d  = out_stat_q;
    out_val_d   = out_val_q;
    out_cnt_d   = out_cnt_q;
    in_ready_o  = 1'b0;
    st_we       = 1'b0;
    st_waddr    = AddrW'(cur_q);
    st_wdata    = SlotUsed;
    kv_we       = 1'b0;
    kv_waddr    = AddrW'(wr_slot);

    // positions register holds the effective modulus
    if (cfg_we_i) begin
      if (cfg_wdata_i == '0) begin
        p_d = PosW'(1);
      end else if (32'(cfg_wdata_i) > 32'(TABLE_DEPTH)) begin
        p_d = PosW'(TABLE_DEPTH);
      end else begin
        p_d = cfg_wdata_i;
      end
    end

    unique case (state_q)
      // sweep the status memory to empty
      StClear: begin
        st_we    = 1'b1;
        st_waddr = clr_q;
        st_wdata = SlotEmpty;
        clr_d    = clr_q + AddrW'(1);
      end
      // take a request word
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d        = operation_i;
          key_d       = key_i[KeyBits-1:0];
          val_d       = value_i;
          h2_d        = step_hash_i;
          sh_d        = first_hash_i;
          bit_d       = '0;
          pos_d       = '0;
          stride_d    = '0;
          have_free_d = 1'b0;
          i_d         = '0;
          res_val_d   = '0;
          res_stat_d  = (operation_i == OpInsert) ? StatFull : StatMiss;
        end
      end
      // first hash mod p, one bit per cycle
      StModFirst: begin
        pos_d = unit_out[PosW-1:0];
        bit_d = bit_q + BitCntW'(1);
        if (bit_q == BitCntW'(HashW - 1)) begin
          sh_d = h2_q;
        end else begin
          sh_d = {sh_q[HashW-2:0], 1'b0};
        end
      end
      // step hash mod p, one bit per cycle
      StModStep: begin
        stride_d = unit_out[PosW-1:0];
        bit_d    = bit_q + BitCntW'(1);
        sh_d     = {sh_q[HashW-2:0], 1'b0};
      end
      // read the slot, advance the probe position
      StProbe: begin
        cur_d = pos_q;
        pos_d = unit_out[PosW-1:0];
      end
      // act on the slot read
      StCheck: begin
        i_d = i_q + PosW'(1);
        if (op_q == OpInsert) begin
          if (chk_match) begin
            res_stat_d = StatDup;
          end else if (chk_finish) begin
            if (have_free_q || chk_free) begin
              st_we      = 1'b1;
              st_waddr   = AddrW'(wr_slot);
              st_wdata   = SlotUsed;
              kv_we      = 1'b1;
              count_d    = count_q + CntW'(1);
              res_stat_d = StatOk;
            end else begin
              res_stat_d = StatFull;
            end
          end else if (chk_free && !have_free_q) begin
            free_d      = cur_q;
            have_free_d = 1'b1;
          end
        end else if (chk_match) begin
          res_stat_d = StatOk;
          res_val_d  = val_rdata;
          if (op_q == OpRemove) begin
            st_we    = 1'b1;
            st_waddr = AddrW'(cur_q);
            st_wdata = SlotVacated;
            if (count_q != '0) begin
              count_d = count_q - CntW'(1);
            end
          end
        end else begin
          res_stat_d = StatMiss;
        end
      end
      // hand the result to the output register
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_stat_d  = res_stat_q;
          out_val_d   = res_val_q;
          out_cnt_d   = count_q;
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      p_q         <= PosReset;
      count_q     <= '0;
      clr_q       <= '0;
      bit_q       <= '0;
      i_q         <= '0;
      have_free_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      p_q         <= p_d;
      count_q     <= count_d;
      clr_q       <= clr_d;
      bit_q       <= bit_d;
      i_q         <= i_d;
      have_free_q <= have_free_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    key_q      <= key_d;
    val_q      <= val_d;
    h2_q       <= h2_d;
    sh_q       <= sh_d;
    pos_q      <= pos_d;
    stride_q   <= stride_d;
    cur_q      <= cur_d;
    free_q     <= free_d;
    res_stat_q <= res_stat_d;
    res_val_q  <= res_val_d;
    out_stat_q <= out_stat_d;
    out_val_q  <= out_val_d;
    out_cnt_q  <= out_cnt_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_stat_q;
  assign found_value_o = out_val_q;
  assign entry_count_o = out_cnt_q;

endmodule

### sim/double_hash_open_table_tb.sv
// self-checking testbench for the double-hashing open-addressed table
module double_hash_open_table_tb
  import dhot_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          TableDepth = 1024;
  localparam int unsigned CycleLimit = 10_000_000;
  localparam int          TailCycles = 8;

  // one answer of the table as it leaves the result channel
  typedef struct packed {
    logic [1:0]        status;
    logic [ValueW-1:0] found_value;
    logic [CntW-1:0]   entry_count;
  } table_answer_t;

  // a key with the hashes that the requester computes for it
  typedef struct packed {
    logic [KeyInW-1:0] key;
    logic [HashW-1:0]  first;
    logic [HashW-1:0]  step;
  } key_record_t;

  logic              clk_i         = 1'b1;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic [PosW-1:0]   cfg_wdata_i   = '0;
  logic              in_valid_i    = 1'b0;
  logic              in_ready_o;
  logic [1:0]        operation_i   = OpInsert;
  logic [KeyInW-1:0] key_i         = '0;
  logic [ValueW-1:0] value_i       = '0;
  logic [HashW-1:0]  first_hash_i  = '0;
  logic [HashW-1:0]  step_hash_i   = '0;
  logic              out_valid_o;
  logic              out_ready_i   = 1'b0;
  logic [1:0]        status_o;
  logic [ValueW-1:0] found_value_o;
  logic [CntW-1:0]   entry_count_o;

  // mirror of the table contents and of the positions register
  logic [1:0]        slot_state_m [TableDepth];
  logic [KeyInW-1:0] slot_key_m   [TableDepth];
  logic [ValueW-1:0] slot_value_m [TableDepth];
  int unsigned       used_count_m;
  logic [PosW-1:0]   positions_m = PosW'(TableDepth);

  table_answer_t table_answers [$];
  int unsigned   error_count;
  int unsigned   send_idle_pct;
  int unsigned   ready_stall_pct;
  int unsigned   hold_off_cycles;
  int unsigned   cycle_count;

  double_hash_open_table dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .operation_i   (operation_i),
    .key_i         (key_i),
    .value_i       (value_i),
    .first_hash_i  (first_hash_i),
    .step_hash_i   (step_hash_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .found_value_o (found_value_o),
    .entry_count_o (entry_count_o)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b0;
    #6 clk_i = 1'b1;
  end

  // ---------------------------------------------------------------------
  // table mirror
  // ---------------------------------------------------------------------

  // positions register as the probe logic sees it
  function automatic int unsigned active_positions();
    int unsigned p;
    p = positions_m;
    if (p == 0) p = 1;
    if (p > TableDepth) p = TableDepth;
    return p;
  endfunction

  // slot visited by probe number idx, exact arithmetic
  function automatic int unsigned probe_index(logic [HashW-1:0] h1, logic [HashW-1:0] h2,
                                              int unsigned idx, int unsigned p);
    longint unsigned sum;
    sum = {32'd0, h1} + 64'(idx) * {32'd0, h2};
    return int'(sum % 64'(p));
  endfunction

  // slot holding the key on its probe path, -1 when absent
  function automatic int find_slot(logic [KeyInW-1:0] key, logic [HashW-1:0] h1,
                                   logic [HashW-1:0] h2, int unsigned p);
    int unsigned s;
    for (int unsigned i = 0; i < p; i++) begin
      s = probe_index(h1, h2, i, p);
      if (slot_state_m[s] == SlotEmpty) return -1;
      if (slot_state_m[s] == SlotUsed && slot_key_m[s] == key) return int'(s);
    end
    return -1;
  endfunction

  // apply one request to the mirror and return the answer it produces
  function automatic table_answer_t hash_table_access(logic [1:0] op, logic [KeyInW-1:0] key,
      logic [ValueW-1:0] value, logic [HashW-1:0] h1, logic [HashW-1:0] h2);
    table_answer_t ans;
    int unsigned   p;
    int unsigned   s;
    int            hit;
    p = active_positions();
    ans.status = StatMiss;
    ans.found_value = '0;
    case (op)
      OpInsert: begin
        if (used_count_m >= p) begin
          ans.status = StatFull;
        end else if (find_slot(key, h1, h2, p) >= 0) begin
          ans.status = StatDup;
        end else begin
          // first empty or vacated slot on the path, full if none
          ans.status = StatFull;
          for (int unsigned i = 0; i < p; i++) begin
            s = probe_index(h1, h2, i, p);
            if (slot_state_m[s] != SlotUsed) begin
              slot_state_m[s] = SlotUsed;
              slot_key_m[s] = key;
              slot_value_m[s] = value;
              used_count_m++;
              ans.status = StatOk;
              break;
            end
          end
        end
      end
      OpRemove: begin
        hit = find_slot(key, h1, h2, p);
        if (hit >= 0) begin
          ans.found_value = slot_value_m[hit];
          slot_state_m[hit] = SlotVacated;
          if (used_count_m > 0) used_count_m--;
          ans.status = StatOk;
        end
      end
      OpLookup: begin
        hit = find_slot(key, h1, h2, p);
        if (hit >= 0) begin
          ans.found_value = slot_value_m[hit];
          ans.status = StatOk;
        end
      end
      default: begin
        // reserved code leaves the table alone
      end
    endcase
    ans.entry_count = CntW'(used_count_m);
    return ans;
  endfunction

  // ---------------------------------------------------------------------
  // channel drivers and answer checker
  // ---------------------------------------------------------------------

  task automatic flag_error(string what, longint unsigned got, longint unsigned want);
    error_count++;
    $display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
  endtask

  // offer one request word, hold it until taken, then update the mirror
  task automatic send_word(logic [1:0] op, logic [KeyInW-1:0] key, logic [ValueW-1:0] value,
                           logic [HashW-1:0] h1, logic [HashW-1:0] h2);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    operation_i  <= op;
    key_i        <= key;
    value_i      <= value;
    first_hash_i <= h1;
    step_hash_i  <= h2;
    do @(posedge clk_i); while (!in_ready_o);
    table_answers.push_back(hash_table_access(op, key, value, h1, h2));
  endtask

  // stop offering and wait until every answer has come back
  task automatic drain_answers();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (table_answers.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // positions register write, only while the block is idle
  task automatic write_positions(logic [PosW-1:0] positions);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= positions;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    positions_m = positions;
  endtask

  // remove every stored key by pointing the first probe straight at its slot
  task automatic vacate_all_slots();
    int unsigned p;
    p = active_positions();
    for (int unsigned s = 0; s < p; s++) begin
      if (slot_state_m[s] == SlotUsed)
        send_word(OpRemove, slot_key_m[s], $urandom,
                  HashW'(s + p * $urandom_range(0, 4000)), $urandom);
    end
  endtask

  // result-side ready: a long hold-off when asked, else random stalls
  always @(negedge clk_i) begin
    if (hold_off_cycles != 0) begin
      hold_off_cycles--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= ready_stall_pct);
    end
  end

  // compare each answer word with the oldest one predicted
  always @(posedge clk_i) begin : check_answer
    table_answer_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (table_answers.size() == 0) begin
        flag_error("word with nothing pending", status_o, 0);
      end else begin
        want = table_answers.pop_front();
        if (status_o !== want.status) flag_error("status", status_o, want.status);
        if (found_value_o !== want.found_value)
          flag_error("found_value", found_value_o, want.found_value);
        if (entry_count_o !== want.entry_count)
          flag_error("entry_count", entry_count_o, want.entry_count);
      end
    end
  end

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // every operation and the field extremes on the full-size table
  task automatic test_basic_ops();
    send_word(OpLookup, '0, '0, '0, '0);
    send_word(OpInsert, '0, '0, '0, '0);
    send_word(OpInsert, '1, '1, '1, '1);
    send_word(OpInsert, '0, 32'h5a5a_a5a5, '0, '0);
    send_word(OpLookup, '1, '0, '1, '1);
    send_word(OpRemove, '0, '1, '0, '0);
    send_word(OpLookup, '0, '0, '0, '0);
    send_word(OpReserved, '1, '1, '1, '1);
    send_word(OpRemove, 32'h0bad_0001, '0, 32'h0000_0010, 32'h0000_0003);
    drain_answers();
  endtask

  // probe path covering only some slots: no free slot, then a full table
  task automatic test_no_free_slot();
    write_positions(PosW'(6));
    send_word(OpInsert, 32'h1111_000a, 32'h0000_00a0, 32'd0, 32'd2);
    send_word(OpInsert, 32'h1111_000b, 32'h0000_00b0, 32'd6, 32'd2);
    send_word(OpInsert, 32'h1111_000c, 32'h0000_00c0, 32'd12, 32'd8);
    send_word(OpInsert, 32'h1111_000d, 32'h0000_00d0, 32'd0, 32'd2);
    send_word(OpLookup, 32'h1111_000d, '0, 32'd0, 32'd2);
    send_word(OpInsert, 32'h1111_000e, 32'h0000_00e0, 32'd1, 32'd2);
    send_word(OpInsert, 32'h1111_000f, 32'h0000_00f0, 32'd3, 32'd0);
    send_word(OpInsert, 32'h1111_0010, 32'h0000_0100, 32'd5, 32'd1);
    send_word(OpRemove, 32'h1111_000b, '0, 32'd0, 32'd2);
    send_word(OpInsert, 32'h1111_0010, 32'h0000_0100, 32'd5, 32'd1);
    drain_answers();
  endtask

  // zero positions behaves as a single slot, older entries beyond slot 0 out of reach
  task automatic test_single_position();
    write_positions('0);
    send_word(OpInsert, 32'h2222_0001, $urandom, $urandom, $urandom);
    send_word(OpLookup, 32'h1111_000a, '0, $urandom, $urandom);
    send_word(OpRemove, 32'h1111_000a, '0, $urandom, $urandom);
    send_word(OpLookup, 32'h1111_000e, '0, 32'd1, 32'd2);
    drain_answers();
  endtask

  // positions above the depth act as the full depth; clear the table after
  task automatic test_oversize_positions();
    write_positions('1);
    send_word(OpLookup, '1, '0, '1, '1);
    send_word(OpInsert, '1, '0, 32'h0000_0400, 32'h0000_0001);
    vacate_all_slots();
    drain_answers();
  endtask

  // receiver holds off for a long stretch while requests keep coming
  task automatic test_backpressure();
    key_record_t rec [8];
    send_idle_pct   = 0;
    ready_stall_pct = 0;
    write_positions(PosW'(16));
    foreach (rec[i]) rec[i] = {$urandom, $urandom, $urandom};
    @(posedge clk_i);
    hold_off_cycles = 400;
    foreach (rec[i]) send_word(OpInsert, rec[i].key, $urandom, rec[i].first, rec[i].step);
    foreach (rec[i]) send_word(OpLookup, rec[i].key, $urandom, rec[i].first, rec[i].step);
    vacate_all_slots();
    drain_answers();
  endtask

  // random traffic over a pool of keys with consistent hashes
  task automatic test_random_phase(int unsigned positions, int unsigned word_count,
                                   int unsigned idle_pct, int unsigned stall_pct);
    key_record_t pool [$];
    key_record_t rec;
    int unsigned roll;
    int unsigned pool_len;
    send_idle_pct   = idle_pct;
    ready_stall_pct = stall_pct;
    write_positions(PosW'(positions));
    pool_len = ((positions * 2 < 40) ? positions * 2 : 40) + 2;
    repeat (pool_len) begin
      rec.key   = ($urandom_range(3) == 0) ? KeyInW'($urandom_range(15)) : $urandom;
      rec.first = $urandom;
      rec.step  = $urandom;
      pool.push_back(rec);
    end
    repeat (word_count) begin
      rec  = pool[$urandom_range(pool.size() - 1)];
      roll = $urandom_range(99);
      if (roll < 45)
        send_word(OpInsert, rec.key, $urandom, rec.first, rec.step);
      else if (roll < 70)
        send_word(OpRemove, rec.key, $urandom, rec.first, rec.step);
      else if (roll < 95)
        send_word(OpLookup, rec.key, $urandom, rec.first, rec.step);
      else if (roll < 98)
        send_word(OpReserved, $urandom, $urandom, $urandom, $urandom);
      else
        // known key reached through unrelated hashes
        send_word(2'($urandom_range(2)), rec.key, $urandom, $urandom, $urandom);
    end
    vacate_all_slots();
    drain_answers();
  endtask

  // ---------------------------------------------------------------------
  // run sequence
  // ---------------------------------------------------------------------

  initial begin
    foreach (slot_state_m[i]) slot_state_m[i] = SlotEmpty;
    used_count_m    = 0;
    error_count     = 0;
    send_idle_pct   = 0;
    ready_stall_pct = 0;
    hold_off_cycles = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_basic_ops();
    test_no_free_slot();
    test_single_position();
    test_oversize_positions();
    test_random_phase(8, 110, 0, 0);
    test_backpressure();
    test_random_phase(13, 110, 55, 0);
    test_random_phase(16, 110, 0, 55);
    test_random_phase(5, 100, 27, 27);
    test_random_phase(1, 40, 55, 0);
    test_random_phase(64, 120, 0, 55);
    test_random_phase(1025, 60, 27, 27);
    test_random_phase(11, 110, 0, 0);

    repeat (TailCycles) @(posedge clk_i);
    if (error_count == 0 && table_answers.size() == 0) begin
      $display("** double_hash_open_table: PASSED **");
    end else begin
      $display("** double_hash_open_table: FAILED **");
    end
    $finish;
  end

  // watchdog on the whole run
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("** double_hash_open_table: FAILED **");
    $finish;
  end

endmodule
